// ===== hdl/fpa_pkg.sv =====
// shared types, operation codes and defaults for the fixed-point alu
package fpa_pkg;

    // default number of fraction bits
    localparam int FRAC_BITS_DEF = 8;

    // quotient bits resolved in each divider stage
    localparam int DIV_BITS_PER_STAGE = 4;

    // operation codes
    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_DIV     = 4'd3;
    localparam logic [3:0] OP_GT      = 4'd4;
    localparam logic [3:0] OP_LT      = 4'd5;
    localparam logic [3:0] OP_GE      = 4'd6;
    localparam logic [3:0] OP_LE      = 4'd7;
    localparam logic [3:0] OP_EQ      = 4'd8;
    localparam logic [3:0] OP_NE      = 4'd9;
    localparam logic [3:0] OP_MIN     = 4'd10;
    localparam logic [3:0] OP_MAX     = 4'd11;
    localparam logic [3:0] OP_INC     = 4'd12;
    localparam logic [3:0] OP_DEC     = 4'd13;
    localparam logic [3:0] OP_TOINT   = 4'd14;
    localparam logic [3:0] OP_FROMINT = 4'd15;

    // side information that rides alongside the divider data
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] quick;
        logic [31:0] mulr;
        logic        cmp;
        logic        dz;
        logic        neg;
    } fpa_side_t;

endpackage

// ===== hdl/fpa_prep.sv =====
// input register, simple operations, multiplier and divider set-up
module fpa_prep
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int WORK_W = 32 + FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic               down_ready,
    output logic               s_valid,
    output fpa_side_t          s_side,
    output logic [31:0]        s_divisor,
    output logic [WORK_W-1:0]  s_work
);

    localparam logic [31:0] FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [3:0]         s1_kind_reg;
    logic signed [31:0] s1_a_reg;
    logic signed [31:0] s1_b_reg;
    logic               s1_advance;

    logic               s2_valid_reg;
    logic               s2_valid_next;
    fpa_side_t          s2_side_reg;
    fpa_side_t          s2_side_next;
    logic [31:0]        s2_divisor_reg;
    logic [31:0]        s2_divisor_next;
    logic [WORK_W-1:0]  s2_work_reg;
    logic [WORK_W-1:0]  s2_work_next;
    logic               s2_advance;

    logic signed [63:0] prod;
    logic signed [31:0] tsum;
    logic signed [31:0] toint_v;
    logic [31:0]        abs_a;
    logic [31:0]        abs_b;
    logic               le_ab;
    logic               ge_ab;

    // a stage moves when it is empty or the next one takes its word
    assign s2_advance = !s2_valid_reg || down_ready;
    assign s1_advance = !s1_valid_reg || s2_advance;
    assign in_ready   = s1_advance;

    assign s1_valid_next = s1_advance ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_advance ? s1_valid_reg : s2_valid_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && in_valid)
        begin
            s1_kind_reg <= kind;
            s1_a_reg    <= operand_a;
            s1_b_reg    <= operand_b;
        end
    end

    // simple operations, product and divider operands
    always_comb
    begin
        prod    = 64'(s1_a_reg) * 64'(s1_b_reg);
        tsum    = s1_a_reg + $signed(s1_a_reg[31] ? FRAC_MASK : 32'd0);
        toint_v = tsum >>> FRAC_BITS;
        abs_a   = s1_a_reg[31] ? (~s1_a_reg + 32'd1) : s1_a_reg;
        abs_b   = s1_b_reg[31] ? (~s1_b_reg + 32'd1) : s1_b_reg;
        le_ab   = s1_a_reg <= s1_b_reg;
        ge_ab   = s1_a_reg >= s1_b_reg;

        s2_side_next       = '0;
        s2_side_next.kind  = s1_kind_reg;
        s2_side_next.mulr  = prod[FRAC_BITS+31:FRAC_BITS];
        s2_side_next.dz    = (s1_kind_reg == OP_DIV) && (s1_b_reg == 32'sd0);
        s2_side_next.neg   = s1_a_reg[31] ^ s1_b_reg[31];

        case (s1_kind_reg)
            OP_ADD:     s2_side_next.quick = s1_a_reg + s1_b_reg;
            OP_SUB:     s2_side_next.quick = s1_a_reg - s1_b_reg;
            OP_GT:      s2_side_next.cmp   = s1_a_reg > s1_b_reg;
            OP_LT:      s2_side_next.cmp   = s1_a_reg < s1_b_reg;
            OP_GE:      s2_side_next.cmp   = ge_ab;
            OP_LE:      s2_side_next.cmp   = le_ab;
            OP_EQ:      s2_side_next.cmp   = s1_a_reg == s1_b_reg;
            OP_NE:      s2_side_next.cmp   = s1_a_reg != s1_b_reg;
            OP_MIN:     s2_side_next.quick = le_ab ? s1_a_reg : s1_b_reg;
            OP_MAX:     s2_side_next.quick = ge_ab ? s1_a_reg : s1_b_reg;
            OP_INC:     s2_side_next.quick = s1_a_reg + 32'sd1;
            OP_DEC:     s2_side_next.quick = s1_a_reg - 32'sd1;
            OP_TOINT:   s2_side_next.quick = toint_v;
            OP_FROMINT: s2_side_next.quick = s1_a_reg <<< FRAC_BITS;
            default:    s2_side_next.quick = 32'd0;
        endcase

        s2_divisor_next = abs_b;
        s2_work_next    = WORK_W'(abs_a) << FRAC_BITS;
    end

    // operation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_advance && s1_valid_reg)
        begin
            s2_side_reg    <= s2_side_next;
            s2_divisor_reg <= s2_divisor_next;
            s2_work_reg    <= s2_work_next;
        end
    end

    assign s_valid   = s2_valid_reg;
    assign s_side    = s2_side_reg;
    assign s_divisor = s2_divisor_reg;
    assign s_work    = s2_work_reg;

endmodule

// ===== hdl/fpa_div_stage.sv =====
// one stage of the restoring divider, resolving STEPS quotient bits per stage
module fpa_div_stage
    import fpa_pkg::*;
#(
    parameter int WORK_W = 32 + FRAC_BITS_DEF,
    parameter int STEPS  = DIV_BITS_PER_STAGE
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  fpa_side_t         up_side,
    input  logic [31:0]       up_divisor,
    input  logic [31:0]       up_rem,
    input  logic [WORK_W-1:0] up_work,
    input  logic              down_ready,
    output logic              s_valid,
    output fpa_side_t         s_side,
    output logic [31:0]       s_divisor,
    output logic [31:0]       s_rem,
    output logic [WORK_W-1:0] s_work
);

    logic              valid_reg;
    logic              valid_next;
    fpa_side_t         side_reg;
    logic [31:0]       divisor_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       rem_next;
    logic [WORK_W-1:0] work_reg;
    logic [WORK_W-1:0] work_next;
    logic              advance;

    assign advance    = !valid_reg || down_ready;
    assign up_ready   = advance;
    assign valid_next = advance ? up_valid : valid_reg;

    // shift in one dividend bit per step, subtract where the divisor fits
    always_comb
    begin
        logic [32:0] trial;
        rem_next  = up_rem;
        work_next = up_work;
        for (int j = 0; j < STEPS; j++)
        begin
            trial     = {rem_next, work_next[WORK_W-1]};
            work_next = work_next << 1;
            if (trial >= {1'b0, up_divisor})
            begin
                trial        = trial - {1'b0, up_divisor};
                work_next[0] = 1'b1;
            end
            rem_next = trial[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            side_reg    <= up_side;
            divisor_reg <= up_divisor;
            rem_reg     <= rem_next;
            work_reg    <= work_next;
        end
    end

    assign s_valid   = valid_reg;
    assign s_side    = side_reg;
    assign s_divisor = divisor_reg;
    assign s_rem     = rem_reg;
    assign s_work    = work_reg;

endmodule

// ===== hdl/fpa_final.sv =====
// quotient sign fix, result selection and output register
module fpa_final
    import fpa_pkg::*;
#(
    parameter int WORK_W = 32 + FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  fpa_side_t          up_side,
    input  logic [WORK_W-1:0]  up_work,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result,
    output logic               compare_true,
    output logic               divide_by_zero
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic        cmp_reg;
    logic        dz_reg;
    logic [31:0] quot;
    logic        advance;

    assign advance    = !valid_reg || !out_stall;
    assign up_ready   = advance;
    assign valid_next = advance ? up_valid : valid_reg;

    // quotient keeps its low 32 bits, sign applied afterwards
    always_comb
    begin
        quot = up_side.neg ? (~up_work[31:0] + 32'd1) : up_work[31:0];
        case (up_side.kind)
            OP_MUL:  result_next = up_side.mulr;
            OP_DIV:  result_next = up_side.dz ? 32'd0 : quot;
            default: result_next = up_side.quick;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            result_reg <= result_next;
            cmp_reg    <= up_side.cmp;
            dz_reg     <= up_side.dz;
        end
    end

    assign out_valid      = valid_reg;
    assign result         = $signed(result_reg);
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

endmodule

// ===== hdl/fixed_point_alu_core.sv =====
// top level of the pipelined signed fixed-point alu
//
// input channel: kind, operand_a and operand_b with in_valid / in_stall; a word
// is taken at a rising edge where in_valid is high and in_stall is low.
// output channel: result, compare_true and divide_by_zero with out_valid /
// out_stall; every input word gives exactly one output word, in order.
// throughput: one word per cycle while out_stall is low. every operation
// passes the same stages: input, operation, the divider stages of the
// restoring divider (four quotient bits per stage) and the output register.
// each stage holds its word until the next one can take it, so a stall at the
// output fills the pipeline's empty slots before in_stall is raised; nothing
// is dropped or repeated.
// reset (rst_n low, asynchronous) empties the pipeline; out_valid falls and
// the block accepts words again in the first cycle after reset.
module fixed_point_alu_core
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result,
    output logic               compare_true,
    output logic               divide_by_zero
);

    localparam int WORK_W     = 32 + FRAC_BITS;
    localparam int DIV_STAGES = (WORK_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

    logic              in_ready;
    logic              valid_chain   [DIV_STAGES+1];
    logic              ready_chain   [DIV_STAGES+1];
    fpa_side_t         side_chain    [DIV_STAGES+1];
    logic [31:0]       divisor_chain [DIV_STAGES+1];
    logic [31:0]       rem_chain     [DIV_STAGES+1];
    logic [WORK_W-1:0] work_chain    [DIV_STAGES+1];

    assign in_stall     = !in_ready;
    assign rem_chain[0] = 32'd0;

    // input and operation stages
    fpa_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .down_ready (ready_chain[0]),
        .s_valid    (valid_chain[0]),
        .s_side     (side_chain[0]),
        .s_divisor  (divisor_chain[0]),
        .s_work     (work_chain[0])
    );

    // divider stages, the last one takes whatever bits remain
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        localparam int LEFT  = WORK_W - i * DIV_BITS_PER_STAGE;
        localparam int STEPS = (LEFT < DIV_BITS_PER_STAGE) ? LEFT : DIV_BITS_PER_STAGE;

        fpa_div_stage #(
            .WORK_W (WORK_W),
            .STEPS  (STEPS)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (valid_chain[i]),
            .up_ready   (ready_chain[i]),
            .up_side    (side_chain[i]),
            .up_divisor (divisor_chain[i]),
            .up_rem     (rem_chain[i]),
            .up_work    (work_chain[i]),
            .down_ready (ready_chain[i+1]),
            .s_valid    (valid_chain[i+1]),
            .s_side     (side_chain[i+1]),
            .s_divisor  (divisor_chain[i+1]),
            .s_rem      (rem_chain[i+1]),
            .s_work     (work_chain[i+1])
        );
    end

    // result selection and output register
    fpa_final #(
        .WORK_W (WORK_W)
    ) u_final (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (valid_chain[DIV_STAGES]),
        .up_ready       (ready_chain[DIV_STAGES]),
        .up_side        (side_chain[DIV_STAGES]),
        .up_work        (work_chain[DIV_STAGES]),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero)
    );

endmodule

// ===== test/fpa_result_checker.sv =====
// result checker for the fixed-point alu: predicts each word and compares it at the output
`timescale 1ns / 1ps

module fpa_result_checker
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] result,
    input  logic               compare_true,
    input  logic               divide_by_zero,
    output int                 mismatches,
    output int                 outstanding,
    output int                 checked
);

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] value;
        logic               flag;
        logic               dz;
    } fpa_outcome_t;

    // words accepted at the input whose results are still to come, oldest first
    fpa_outcome_t pending_outcomes[$];

    // q-format arithmetic in 64 bits, wrapped back to 32
    function automatic fpa_outcome_t alu_outcome(input logic [3:0] op,
                                                 input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        longint       sa;
        longint       sb;
        longint       wide;
        fpa_outcome_t o;
        sa = a;
        sb = b;
        wide = 0;
        o = '0;
        o.op = op;
        case (op)
            OP_ADD:     wide = sa + sb;
            OP_SUB:     wide = sa - sb;
            // floor shift of the full product
            OP_MUL:     wide = (sa * sb) >>> FRAC_BITS;
            OP_DIV:
            begin
                if (sb == 0)
                    o.dz = 1'b1;
                else
                    wide = (sa <<< FRAC_BITS) / sb;
            end
            OP_GT:      o.flag = (sa > sb);
            OP_LT:      o.flag = (sa < sb);
            OP_GE:      o.flag = (sa >= sb);
            OP_LE:      o.flag = (sa <= sb);
            OP_EQ:      o.flag = (sa == sb);
            OP_NE:      o.flag = (sa != sb);
            OP_MIN:     wide = (sa <= sb) ? sa : sb;
            OP_MAX:     wide = (sa >= sb) ? sa : sb;
            OP_INC:     wide = sa + 1;
            OP_DEC:     wide = sa - 1;
            // truncates toward zero
            OP_TOINT:   wide = sa / (longint'(1) <<< FRAC_BITS);
            OP_FROMINT: wide = sa <<< FRAC_BITS;
            default:    wide = 0;
        endcase
        o.value = wide[31:0];
        return o;
    endfunction

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        checked = 0;
    end

    // compare outgoing words, then record incoming ones
    always @(posedge clk)
    begin : watch
        fpa_outcome_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word %h/%b/%b with nothing expected",
                             $time, result, compare_true, divide_by_zero);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    checked++;
                    if (result !== want.value)
                    begin
                        mismatches++;
                        $display("%0t: op %0d result expected %h actual %h",
                                 $time, want.op, want.value, result);
                    end
                    if (compare_true !== want.flag)
                    begin
                        mismatches++;
                        $display("%0t: op %0d compare_true expected %b actual %b",
                                 $time, want.op, want.flag, compare_true);
                    end
                    if (divide_by_zero !== want.dz)
                    begin
                        mismatches++;
                        $display("%0t: op %0d divide_by_zero expected %b actual %b",
                                 $time, want.op, want.dz, divide_by_zero);
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_outcomes.push_back(alu_outcome(kind, operand_a, operand_b));
            outstanding <= pending_outcomes.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// stimulus and verdict for the fixed-point alu core
`timescale 1ns / 1ps

module testbench;
    import fpa_pkg::*;

    localparam int                 CYCLE_LIMIT = 200000;
    localparam int                 HOLD_CYCLES = 80;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [3:0]         kind = OP_ADD;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;

    int mismatches;
    int outstanding;
    int checked;
    int cycles = 0;

    // idling controls for the sender and receiver processes, set by the stimulus
    bit sender_idles = 1'b1;
    bit rx_quiet = 1'b0;
    bit hold_output = 1'b0;

    fixed_point_alu_core #(.FRAC_BITS(FRAC_BITS_DEF)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero)
    );

    fpa_result_checker #(.FRAC_BITS(FRAC_BITS_DEF)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timed out after %0d cycles", $time, cycles);
            $display("[fixed_point_alu_core] ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold on request, none when quiet
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_output = 1'b0;
            end
            else if (!rx_quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // offer one word and wait until the block takes it
    task automatic send_word(input logic [3:0] op, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // operand mix: full range, small values, extremes and exact q-format values
    function automatic logic signed [31:0] pick_operand();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 8191) - 4096;
            4:       v = $urandom >> $urandom_range(1, 31);
            5:       v = -($urandom >> $urandom_range(1, 31));
            6:       v = ($urandom_range(0, 511) - 256) << 8;
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = -1;
                    3:       v = MAXV;
                    4:       v = MINV;
                    5:       v = 256;
                    default: v = -256;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_random(input int count);
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        repeat (count)
        begin
            op = 4'($urandom_range(0, 15));
            a = pick_operand();
            if ($urandom_range(0, 7) == 0)
                b = a;
            else if (op == OP_DIV && $urandom_range(0, 7) == 0)
                b = 0;
            else
                b = pick_operand();
            send_word(op, a, b);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        bit failed;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: wrap-around, rounding direction, zero divisor, every op
        send_word(OP_ADD, MAXV, 1);
        send_word(OP_SUB, MINV, 1);
        send_word(OP_MUL, MAXV, MAXV);
        send_word(OP_MUL, MINV, MINV);
        send_word(OP_MUL, -1, 1);
        send_word(OP_MUL, 32'sh00000180, -32'sh00000280);
        send_word(OP_DIV, 32'sh00000300, 0);
        send_word(OP_DIV, MINV, -1);
        send_word(OP_DIV, -32'sh00000100, 32'sh00000300);
        send_word(OP_DIV, MAXV, MINV);
        send_word(OP_GT, MAXV, MINV);
        send_word(OP_LT, MAXV, MINV);
        send_word(OP_GE, -5, -5);
        send_word(OP_LE, MINV, MINV);
        send_word(OP_EQ, 32'sh12345678, 32'sh12345678);
        send_word(OP_NE, 0, -1);
        send_word(OP_MIN, MINV, MAXV);
        send_word(OP_MAX, MINV, MAXV);
        send_word(OP_INC, MAXV, 0);
        send_word(OP_DEC, MINV, 0);
        send_word(OP_TOINT, -1, 0);
        send_word(OP_TOINT, MINV, 0);
        send_word(OP_FROMINT, MAXV, 0);
        send_word(OP_FROMINT, -3, 0);

        // random traffic with idling on both sides
        send_random(280);

        // long output hold while the sender keeps offering, so the pipe backs up
        sender_idles = 1'b0;
        hold_output = 1'b1;
        send_random(40);
        sender_idles = 1'b1;

        // sender pause until everything has come back
        drain();

        send_random(250);

        // closing stretch with no idling at all
        sender_idles = 1'b0;
        rx_quiet = 1'b1;
        send_random(60);

        drain();
        repeat (20) @(posedge clk);

        failed = (mismatches != 0) || (outstanding != 0);
        if (outstanding != 0)
            $display("%0t: %0d expected result words never arrived", $time, outstanding);
        $display("checked %0d result words over all sixteen operations, operand extremes,",
                 checked);
        $display("zero divisors, wrapping overflow and a long output hold that filled the pipe");
        if (!failed)
            $display("[fixed_point_alu_core] OK");
        else
            $display("[fixed_point_alu_core] ERROR");
        $finish;
    end

endmodule
